### src/dec_pkg.sv
// Shared types and constants for the double-ended queue core.
`timescale 1ns / 1ps
`default_nettype none

package dec_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;
   localparam int unsigned DATA_W        = 32;
   localparam int unsigned KIND_W        = 2;

   // Operation codes carried on the request channel
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_BACK  = 2'd0,
      KIND_PUSH_FRONT = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_BACK   = 2'd3
   } kind_type;

   typedef logic signed [DATA_W-1:0] data_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic read;
   } cmd_type;

endpackage

`default_nettype wire

### src/dec_req_if.sv
// Request channel interface: operation kind and value to push.
`timescale 1ns / 1ps
`default_nettype none

interface dec_req_if;
   logic              valid;
   logic              ready;
   dec_pkg::kind_type kind;
   dec_pkg::data_type value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

`default_nettype wire

### src/dec_rsp_if.sv
// Response channel interface: queue snapshot after one operation.
`timescale 1ns / 1ps
`default_nettype none

interface dec_rsp_if #(
   parameter int unsigned CNT_W = $clog2(dec_pkg::DEPTH_DEFAULT + 1)
);
   logic              valid;
   logic              ready;
   dec_pkg::data_type front_value;
   dec_pkg::data_type back_value;
   logic [CNT_W-1:0]  count;
   logic              is_empty;
   logic              is_full;
   logic              error;

   modport source (output valid, output front_value, output back_value, output count,
                   output is_empty, output is_full, output error, input ready);
   modport sink   (input valid, input front_value, input back_value, input count,
                   input is_empty, input is_full, input error, output ready);
endinterface

`default_nettype wire

### src/double_ended_queue_core.sv
// Top level of the bounded double-ended queue core.
// The rsp valid rises after the req transaction once the controller has walked execute and
//   memory read; no new req transaction is taken until the rsp transaction completes.
// Each transaction walks load, execute, memory read and response in the controller;
//   the controller holds in the response state while rsp ready stays low.
// Reset: synchronous, active high; clears pointers, count and controller state.
//   Slot contents are not cleared; only written slots are ever shown.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_core #(
   parameter int unsigned DEPTH = dec_pkg::DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dec_req_if.sink    req_chan,
   dec_rsp_if.source  rsp_chan
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   dec_pkg::cmd_type  cmd;
   logic [CNT_W-1:0]  count;

   // Controller: sequence each transaction through the datapath
   dec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // Datapath: hold slots and pointers, drive the response payload
   dec_datapath #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_kind    (req_chan.kind),
      .req_value   (req_chan.value),
      .front_value (rsp_chan.front_value),
      .back_value  (rsp_chan.back_value),
      .count       (count),
      .is_empty    (rsp_chan.is_empty),
      .is_full     (rsp_chan.is_full),
      .error       (rsp_chan.error)
   );

   // The payload stays fixed while rsp valid waits for ready
   assign rsp_chan.count = count;

endmodule

`default_nettype wire

### src/dec_ctrl.sv
// Controller state machine sequencing load, execute, read and response.
`timescale 1ns / 1ps
`default_nettype none

module dec_ctrl (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output dec_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && ready_ff) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      ready_in = (state_in == S_IDLE);
      valid_in = (state_in == S_RESP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready = ready_ff;
   assign rsp_valid = valid_ff;

   assign cmd.load = req_valid && ready_ff;
   assign cmd.exec = (state_ff == S_EXEC);
   assign cmd.read = (state_ff == S_READ);

endmodule

`default_nettype wire

### src/dec_datapath.sv
// Datapath: slot memory, front/back pointers, count and response registers.
`timescale 1ns / 1ps
`default_nettype none

module dec_datapath #(
   parameter int unsigned DEPTH = dec_pkg::DEPTH_DEFAULT,
   parameter int unsigned IDX_W = $clog2(DEPTH),
   parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dec_pkg::cmd_type  cmd,
   input  wire dec_pkg::kind_type req_kind,
   input  wire dec_pkg::data_type req_value,
   output dec_pkg::data_type      front_value,
   output dec_pkg::data_type      back_value,
   output logic [CNT_W-1:0]       count,
   output logic                   is_empty,
   output logic                   is_full,
   output logic                   error
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   dec_pkg::data_type slots [DEPTH];

   dec_pkg::kind_type kind_ff;
   dec_pkg::data_type value_ff;
   logic [IDX_W-1:0]  front_ff;
   logic [IDX_W-1:0]  back_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              err_ff;
   dec_pkg::data_type front_rd_ff;
   dec_pkg::data_type back_rd_ff;

   logic [IDX_W-1:0]  front_next, front_prev, back_next, back_prev, wr_addr;
   logic              empty, full, is_push, refuse;

   assign front_next = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
   assign front_prev = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign back_next  = (back_ff == LAST_IDX) ? '0 : back_ff + 1'b1;
   assign back_prev  = (back_ff == '0) ? LAST_IDX : back_ff - 1'b1;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == FULL_CNT);
   assign is_push = (kind_ff == dec_pkg::KIND_PUSH_BACK) ||
                    (kind_ff == dec_pkg::KIND_PUSH_FRONT);
   assign refuse  = is_push ? full : empty;
   assign wr_addr = (kind_ff == dec_pkg::KIND_PUSH_BACK) ? back_ff : front_prev;

   // Capture the request payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         value_ff <= req_value;
      end
   end

   // Pointer and count update
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec && !refuse) begin
         case (kind_ff)
            dec_pkg::KIND_PUSH_BACK: begin
               back_ff  <= back_next;
               count_ff <= count_ff + 1'b1;
            end
            dec_pkg::KIND_PUSH_FRONT: begin
               front_ff <= front_prev;
               count_ff <= count_ff + 1'b1;
            end
            dec_pkg::KIND_POP_FRONT: begin
               front_ff <= front_next;
               count_ff <= count_ff - 1'b1;
            end
            default: begin
               back_ff  <= back_prev;
               count_ff <= count_ff - 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) err_ff <= refuse;
   end

   // Slot memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.exec && is_push && !full) slots[wr_addr] <= value_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         front_rd_ff <= slots[front_ff];
         back_rd_ff  <= slots[back_prev];
      end
   end

   assign front_value = empty ? '1 : front_rd_ff;
   assign back_value  = empty ? '1 : back_rd_ff;
   assign count       = count_ff;
   assign is_empty    = empty;
   assign is_full     = full;
   assign error       = err_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("count exceeds depth");

   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (front_ff == back_ff))
      else $error("pointers disagree with empty or full count");

   a_refuse_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && refuse) |=>
         ($stable(count_ff) && $stable(front_ff) && $stable(back_ff)))
      else $error("refused operation changed queue state");

   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && !refuse && is_push) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("accepted push did not grow count");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.exec |=> $stable(count_ff))
      else $error("count moved outside execute");

endmodule

`default_nettype wire
